/* design/cale_pkg.sv */
// Shared types and constants for the cursor array list engine.
// No dependencies; every other file of the block imports this package.
package cale_pkg;

	localparam int CAPACITY = 16;
	localparam int DATA_W   = 32;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = IDX_W + 1;
	localparam int ADDR_W   = 3;

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [DATA_W-1:0] word_t;

	typedef enum logic [3:0] {
		OP_INSERT  = 4'd0,
		OP_REMOVE  = 4'd1,
		OP_REPLACE = 4'd2,
		OP_CLEAR   = 4'd3,
		OP_BEGIN   = 4'd4,
		OP_END     = 4'd5,
		OP_NEXT    = 4'd6,
		OP_PRIOR   = 4'd7,
		OP_READ    = 4'd8,
		OP_MOVE    = 4'd9,
		OP_FIND    = 4'd10
	} op_t;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_EMPTY  = 3'd1,
		ST_FULL   = 3'd2,
		ST_RANGE  = 3'd3,
		ST_NOMOVE = 3'd4
	} status_t;

	// register index of capacity_limit
	localparam logic REG_LIMIT = 1'b0;

	typedef struct packed {
		logic  we;
		idx_t  waddr;
		word_t wdata;
		logic  re;
		idx_t  raddr;
	} mem_req_t;

endpackage

/* design/cale_req_if.sv */
// Request channel: valid/ready handshake carrying one list operation.
// Depends on cale_pkg.
interface cale_req_if;
	import cale_pkg::*;

	logic        valid;
	logic        ready;
	logic [3:0]  req_type;
	word_t       data_in;
	idx_t        position;

	modport source(output valid, output req_type, output data_in, output position,
		input ready);
	modport sink(input valid, input req_type, input data_in, input position,
		output ready);

endinterface

/* design/cale_rsp_if.sv */
// Response channel: valid/ready handshake carrying one result per request.
// Depends on cale_pkg.
interface cale_rsp_if;
	import cale_pkg::*;

	logic              valid;
	logic              ready;
	logic [2:0]        status;
	word_t             data_out;
	logic signed [4:0] cursor_pos;
	cnt_t              item_count;

	modport source(output valid, output status, output data_out, output cursor_pos,
		output item_count, input ready);
	modport sink(input valid, input status, input data_out, input cursor_pos,
		input item_count, output ready);

endinterface

/* design/cale_ram.sv */
// Entry store: one write port, one read port, read data registered.
// Depends on cale_pkg.
module cale_ram (
	input  logic               clk,
	input  cale_pkg::mem_req_t mreq,
	output cale_pkg::word_t    rdata
);
	import cale_pkg::*;

	word_t mem_q [CAPACITY];

	always_ff @(posedge clk) begin
		if (mreq.we) begin
			mem_q[mreq.waddr] <= mreq.wdata;
		end
		if (mreq.re) begin
			rdata <= mem_q[mreq.raddr];
		end
	end

endmodule

/* design/cale_ctrl.sv */
// Operation sequencer: holds count and cursor, walks the entry store for
// remove, move and find, and registers the response. Depends on cale_pkg.
module cale_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	cale_req_if.sink           req,
	cale_rsp_if.source         rsp,
	input  cale_pkg::cnt_t     lim,
	output cale_pkg::mem_req_t mreq,
	input  cale_pkg::word_t    rdata
);
	import cale_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_READ, S_HELD, S_SHIFT, S_PUT, S_FIND, S_DONE
	} state_t;

	state_t            state_q;
	cnt_t              count_q;
	logic signed [4:0] cursor_q;
	status_t           status_q;
	word_t             dout_q;
	word_t             word_q;
	word_t             held_q;
	idx_t              pos_q;
	idx_t              idx_q;
	idx_t              last_q;
	logic              up_q;
	logic              move_q;
	logic              rsp_valid_q;
	logic [2:0]        rsp_status_q;
	word_t             rsp_data_q;
	logic signed [4:0] rsp_cursor_q;
	cnt_t              rsp_count_q;

	logic  accept;
	logic  empty;
	idx_t  cur;
	cnt_t  cnt_m1_w;
	cnt_t  cnt_m2_w;
	idx_t  cnt_m1;
	cnt_t  cur_p1;
	logic  match;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign empty     = (count_q == '0);
	assign cur       = empty ? '0 : cursor_q[IDX_W-1:0];
	assign cnt_m1_w  = count_q - CNT_W'(1);
	assign cnt_m2_w  = count_q - CNT_W'(2);
	assign cnt_m1    = cnt_m1_w[IDX_W-1:0];
	assign cur_p1    = {1'b0, cur} + CNT_W'(1);
	assign match     = (rdata == word_q);

	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = rsp_status_q;
	assign rsp.data_out   = rsp_data_q;
	assign rsp.cursor_pos = rsp_cursor_q;
	assign rsp.item_count = rsp_count_q;

	always_comb begin
		mreq = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req.req_type)
						OP_INSERT: begin
							mreq.we    = (count_q < lim);
							mreq.waddr = count_q[IDX_W-1:0];
							mreq.wdata = req.data_in;
						end
						OP_REPLACE: begin
							mreq.we    = !empty;
							mreq.waddr = cur;
							mreq.wdata = req.data_in;
						end
						OP_REMOVE: begin
							mreq.re    = !empty && (cur_p1 < count_q);
							mreq.raddr = cur_p1[IDX_W-1:0];
						end
						OP_READ, OP_FIND: begin
							mreq.re    = !empty;
							mreq.raddr = cur;
						end
						OP_MOVE: begin
							mreq.re    = ({1'b0, req.position} < count_q);
							mreq.raddr = cur;
						end
						default: ;
					endcase
				end
			end
			S_HELD: begin
				mreq.re    = (cur != pos_q);
				mreq.raddr = (cur < pos_q) ? cur + IDX_W'(1) : cur - IDX_W'(1);
			end
			S_SHIFT: begin
				// write the word fetched last cycle, fetch two ahead
				mreq.we    = 1'b1;
				mreq.waddr = idx_q;
				mreq.wdata = rdata;
				mreq.re    = (idx_q != last_q);
				mreq.raddr = up_q ? idx_q + IDX_W'(2) : idx_q - IDX_W'(2);
			end
			S_PUT: begin
				mreq.we    = 1'b1;
				mreq.waddr = pos_q;
				mreq.wdata = held_q;
			end
			S_FIND: begin
				mreq.re    = !match && (idx_q != cnt_m1);
				mreq.raddr = idx_q + IDX_W'(1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			cursor_q     <= -5'sd1;
			status_q     <= ST_OK;
			dout_q       <= '0;
			word_q       <= '0;
			held_q       <= '0;
			pos_q        <= '0;
			idx_q        <= '0;
			last_q       <= '0;
			up_q         <= 1'b0;
			move_q       <= 1'b0;
			rsp_valid_q  <= 1'b0;
			rsp_status_q <= '0;
			rsp_data_q   <= '0;
			rsp_cursor_q <= '0;
			rsp_count_q  <= '0;
		end else begin
			// drop the response once taken; S_DONE handles its own slot
			if (rsp.ready && (state_q != S_DONE)) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						status_q <= ST_OK;
						dout_q   <= '0;
						word_q   <= req.data_in;
						pos_q    <= req.position;
						move_q   <= (req.req_type == OP_MOVE);
						state_q  <= S_DONE;
						case (req.req_type)
							OP_INSERT: begin
								if (count_q >= lim) begin
									status_q <= ST_FULL;
								end else begin
									count_q  <= count_q + CNT_W'(1);
									cursor_q <= $signed(count_q);
								end
							end
							OP_REMOVE: begin
								if (empty) begin
									status_q <= ST_EMPTY;
								end else begin
									count_q <= cnt_m1_w;
									if (count_q == CNT_W'(1)) begin
										cursor_q <= -5'sd1;
									end else if (cur == cnt_m1) begin
										cursor_q <= cursor_q - 5'sd1;
									end
									if (cur_p1 < count_q) begin
										idx_q   <= cur;
										last_q  <= cnt_m2_w[IDX_W-1:0];
										up_q    <= 1'b1;
										state_q <= S_SHIFT;
									end
								end
							end
							OP_REPLACE: begin
								if (empty) status_q <= ST_EMPTY;
							end
							OP_CLEAR: begin
								count_q  <= '0;
								cursor_q <= -5'sd1;
							end
							OP_BEGIN: begin
								if (empty) status_q <= ST_EMPTY;
								else cursor_q <= 5'sd0;
							end
							OP_END: begin
								if (empty) status_q <= ST_EMPTY;
								else cursor_q <= $signed({1'b0, cnt_m1});
							end
							OP_NEXT: begin
								if (empty || cur_p1 >= count_q) status_q <= ST_NOMOVE;
								else cursor_q <= cursor_q + 5'sd1;
							end
							OP_PRIOR: begin
								if (empty || cur == '0) status_q <= ST_NOMOVE;
								else cursor_q <= cursor_q - 5'sd1;
							end
							OP_READ: begin
								if (empty) status_q <= ST_EMPTY;
								else state_q <= S_READ;
							end
							OP_MOVE: begin
								if ({1'b0, req.position} >= count_q) status_q <= ST_RANGE;
								else state_q <= S_HELD;
							end
							OP_FIND: begin
								if (empty) begin
									status_q <= ST_NOMOVE;
								end else begin
									idx_q   <= cur;
									state_q <= S_FIND;
								end
							end
							default: ;
						endcase
					end
				end
				S_READ: begin
					dout_q  <= rdata;
					state_q <= S_DONE;
				end
				S_HELD: begin
					held_q <= rdata;
					if (cur == pos_q) begin
						state_q <= S_DONE;
					end else begin
						idx_q   <= cur;
						up_q    <= (cur < pos_q);
						last_q  <= (cur < pos_q) ? pos_q - IDX_W'(1) : pos_q + IDX_W'(1);
						state_q <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					if (idx_q == last_q) begin
						state_q <= move_q ? S_PUT : S_DONE;
					end else begin
						idx_q <= up_q ? idx_q + IDX_W'(1) : idx_q - IDX_W'(1);
					end
				end
				S_PUT: begin
					state_q <= S_DONE;
				end
				S_FIND: begin
					if (match) begin
						cursor_q <= $signed({1'b0, idx_q});
						state_q  <= S_DONE;
					end else if (idx_q == cnt_m1) begin
						cursor_q <= $signed({1'b0, cnt_m1});
						status_q <= ST_NOMOVE;
						state_q  <= S_DONE;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				S_DONE: begin
					// hold until the response slot is free
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q  <= 1'b1;
						rsp_status_q <= status_q;
						rsp_data_q   <= dout_q;
						rsp_cursor_q <= cursor_q;
						rsp_count_q  <= count_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* design/cursor_array_list_engine.sv */
// Top level of the cursor array list engine: configuration register,
// sequencer and entry store. Depends on cale_pkg, cale_req_if, cale_rsp_if.
//
//   channel  direction  handshake           payload
//   req      in         valid/ready         req_type, data_in, position
//   rsp      out        valid/ready         status, data_out, cursor_pos, item_count
//   apb      in         psel/penable/pready capacity_limit at byte address 0
//
// Insert, replace, clear and cursor moves need no walk; read waits on the read data;
// remove shifts the entries after the cursor down, move shifts those between cursor
// and position and puts the moved entry there, find scans from the cursor to a
// match or the last entry; the store, one read and one write a cycle, paces walks.
// Reset clears count to 0, cursor to -1 and capacity_limit to 16; entries stay as
// they are. A new request is taken while the previous response waits on rsp.ready.
module cursor_array_list_engine (
	input  logic                        clk,
	input  logic                        arst_n,
	cale_req_if.sink                    req,
	cale_rsp_if.source                  rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [cale_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import cale_pkg::*;

	cnt_t     limit_q;
	cnt_t     lim;
	mem_req_t mreq;
	word_t    rdata;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_LIMIT) ? {{(32-CNT_W){1'b0}}, limit_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= CNT_W'(CAPACITY);
		end else if (psel && penable && pwrite && (paddr[2] == REG_LIMIT)) begin
			limit_q <= pwdata[CNT_W-1:0];
		end
	end

	// clamp the limit to 1..CAPACITY
	always_comb begin
		if (limit_q == '0) lim = CNT_W'(1);
		else if (limit_q > CNT_W'(CAPACITY)) lim = CNT_W'(CAPACITY);
		else lim = limit_q;
	end

	cale_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.lim    (lim),
		.mreq   (mreq),
		.rdata  (rdata)
	);

	cale_ram u_ram (
		.clk   (clk),
		.mreq  (mreq),
		.rdata (rdata)
	);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request taken while another is in progress");

	a_no_port_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(mreq.we && mreq.re) |-> (mreq.waddr != mreq.raddr))
		else $error("read and write of the same entry in one cycle");

	a_empty_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> ((rsp.item_count == '0) == (rsp.cursor_pos == -5'sd1)))
		else $error("cursor and item count disagree on an empty list");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.item_count <= CNT_W'(CAPACITY)))
		else $error("item count beyond capacity");

endmodule
